### design/rcvg_pkg.sv
// Shared types and constants for the ribbon chain vertex generator.
package rcvg_pkg;

  // Pair engine sequencer states
  typedef enum logic [3:0] {
    P_IDLE,
    P_FIT,
    P_CROSS,
    P_NORM,
    P_SQ,
    P_ROOT,
    P_RWAIT,
    P_DMUL,
    P_DSTART,
    P_DWAIT,
    P_OUT
  } pair_state_t;

  // Top level chain sequencer states
  typedef enum logic [2:0] {
    T_IDLE,
    T_GO1,
    T_RUN1,
    T_OUT1,
    T_GO2,
    T_RUN2,
    T_OUT2
  } top_state_t;

  // Root/divide unit operation
  typedef enum logic {
    RD_SQRT,
    RD_DIV
  } rd_mode_t;

  typedef struct packed {
    logic     start;
    rd_mode_t mode;
  } rd_req_t;

  // Iteration counts of the bit-serial unit
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 34;

  // Configuration register indexes
  localparam logic [1:0] REG_EYE_X = 2'd0;
  localparam logic [1:0] REG_EYE_Y = 2'd1;
  localparam logic [1:0] REG_EYE_Z = 2'd2;

endpackage

### design/rcvg_mul.sv
// Shared registered 33x33 signed multiplier.
module rcvg_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] prod
);

  // Register the product
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

### design/rcvg_rootdiv.sv
// Bit-serial square root and restoring divider, one result bit per cycle.
module rcvg_rootdiv (
  input  logic                   clk,
  input  logic                   rst,
  input  rcvg_pkg::rd_req_t      req,
  input  logic [63:0]            rad,
  input  logic [63:0]            num,
  input  logic [31:0]            den,
  output logic                   done,
  output logic [31:0]            root,
  output logic [33:0]            quo
);

  logic                busy;
  rcvg_pkg::rd_mode_t  mode;
  logic [5:0]          cnt;
  logic [63:0]         x;
  logic [63:0]         r;
  logic [63:0]         n;
  logic [31:0]         d;
  logic [31:0]         rem;
  logic [33:0]         q;
  logic [63:0]         trial;
  logic [32:0]         sh;
  logic                fits;

  // Trial values of one step
  always_comb begin
    trial = r + n;
    sh    = {rem, n[63]};
    fits  = (sh >= {1'b0, d});
  end

  // Control: count down the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= (req.mode == rcvg_pkg::RD_SQRT) ? 6'(rcvg_pkg::SQRT_STEPS - 1)
                                                : 6'(rcvg_pkg::DIV_STEPS - 1);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then one bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      mode <= req.mode;
      x    <= rad;
      r    <= '0;
      d    <= den;
      q    <= '0;
      rem  <= {2'b00, num[63:34]};
      if (req.mode == rcvg_pkg::RD_SQRT) begin
        n <= 64'h4000_0000_0000_0000;
      end else begin
        n <= {num[33:0], 30'd0};
      end
    end else if (busy) begin
      unique case (mode)
        rcvg_pkg::RD_SQRT: begin
          if (x >= trial) begin
            x <= x - trial;
            r <= (r >> 1) + n;
          end else begin
            r <= r >> 1;
          end
          n <= n >> 2;
        end
        rcvg_pkg::RD_DIV: begin
          rem <= fits ? 32'(sh - {1'b0, d}) : sh[31:0];
          q   <= {q[32:0], fits};
          n   <= n << 1;
        end
        default: begin
          n <= n;
        end
      endcase
    end
  end

  assign root = r[31:0];
  assign quo  = q;

endmodule

### design/rcvg_pair.sv
// Vertex pair engine: tangent/eye cross product, normalize and scale by width.
module rcvg_pair (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] p_in   [3],
  input  logic signed [32:0] tan_in [3],
  input  logic signed [31:0] eye_in [3],
  input  logic [31:0]        hw_in,
  output logic               done,
  output logic signed [31:0] lft [3],
  output logic signed [31:0] rgt [3]
);

  rcvg_pkg::pair_state_t state, state_next;

  logic [2:0]          stp;
  logic signed [31:0]  p   [3];
  logic signed [32:0]  t   [3];
  logic signed [32:0]  e   [3];
  logic signed [30:0]  tf  [3];
  logic signed [30:0]  ef  [3];
  logic [31:0]         hw;
  logic signed [61:0]  cacc;
  logic [60:0]         cm  [3];
  logic                cs  [3];
  logic [61:0]         sum;
  logic [31:0]         len;
  logic [33:0]         q   [3];

  logic signed [32:0]  ma, mb;
  logic signed [65:0]  mprod;
  logic signed [61:0]  prod62;
  logic signed [61:0]  cdiff;
  logic [2:0]          j;
  logic [1:0]          ts, es;
  logic                c_hi, c_mid, c_zero;
  rcvg_pkg::rd_req_t   rd_req;
  logic                rd_done;
  logic [31:0]         rd_root;
  logic [33:0]         rd_quo;
  logic [63:0]         rd_num;
  logic signed [34:0]  off [3];
  logic signed [35:0]  lsum [3];
  logic signed [35:0]  rsum [3];

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [1:0] fit_shift(input logic [32:0] m0, input logic [32:0] m1,
                                           input logic [32:0] m2);
    logic [32:0] o;
    o = m0 | m1 | m2;
    priority if (o[32]) fit_shift = 2'd3;
    else if (o[31])     fit_shift = 2'd2;
    else if (o[30])     fit_shift = 2'd1;
    else                fit_shift = 2'd0;
  endfunction

  function automatic logic signed [30:0] fit_one(input logic signed [32:0] v,
                                                 input logic [1:0] s);
    logic [32:0] sh;
    sh = mag33(v) >> s;
    fit_one = v[32] ? -$signed({1'b0, sh[29:0]}) : $signed({1'b0, sh[29:0]});
  endfunction

  function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
    priority if (v > 36'sd2147483647)       sat36 = 32'sh7FFF_FFFF;
    else if (v < -36'sd2147483648)          sat36 = 32'sh8000_0000;
    else                                    sat36 = v[31:0];
  endfunction

  rcvg_mul u_mul (
    .clk  (clk),
    .a    (ma),
    .b    (mb),
    .prod (mprod)
  );

  rcvg_rootdiv u_rd (
    .clk  (clk),
    .rst  (rst),
    .req  (rd_req),
    .rad  ({2'b00, sum}),
    .num  (rd_num),
    .den  (len),
    .done (rd_done),
    .root (rd_root),
    .quo  (rd_quo)
  );

  // Derived values of the current step
  always_comb begin
    prod62 = mprod[61:0];
    cdiff  = cacc - prod62;
    j      = stp - 3'd1;
    ts     = fit_shift(mag33(t[0]), mag33(t[1]), mag33(t[2]));
    es     = fit_shift(mag33(e[0]), mag33(e[1]), mag33(e[2]));
    c_hi   = (|cm[0][60:30]) | (|cm[1][60:30]) | (|cm[2][60:30]);
    c_mid  = cm[0][29] | cm[1][29] | cm[2][29];
    c_zero = (cm[0] == '0) && (cm[1] == '0) && (cm[2] == '0);
    rd_num = 64'(mprod[61:0]) + 64'(len >> 1);
    for (int k = 0; k < 3; k++) begin
      off[k]  = cs[k] ? -$signed({1'b0, q[k]}) : $signed({1'b0, q[k]});
      lsum[k] = 36'(p[k]) - 36'(off[k]);
      rsum[k] = 36'(p[k]) + 36'(off[k]);
    end
  end

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcvg_pkg::P_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, multiplier operands and root/divide requests
  always_comb begin
    state_next  = state;
    ma          = '0;
    mb          = '0;
    rd_req      = '{start: 1'b0, mode: rcvg_pkg::RD_SQRT};
    unique case (state)
      rcvg_pkg::P_IDLE: begin
        if (start) state_next = rcvg_pkg::P_FIT;
      end
      rcvg_pkg::P_FIT: begin
        state_next = rcvg_pkg::P_CROSS;
      end
      rcvg_pkg::P_CROSS: begin
        unique case (stp)
          3'd0: begin ma = 33'(tf[1]); mb = 33'(ef[2]); end
          3'd1: begin ma = 33'(tf[2]); mb = 33'(ef[1]); end
          3'd2: begin ma = 33'(tf[2]); mb = 33'(ef[0]); end
          3'd3: begin ma = 33'(tf[0]); mb = 33'(ef[2]); end
          3'd4: begin ma = 33'(tf[0]); mb = 33'(ef[1]); end
          3'd5: begin ma = 33'(tf[1]); mb = 33'(ef[0]); end
          default: begin ma = '0; mb = '0; end
        endcase
        if (stp == 3'd6) state_next = rcvg_pkg::P_NORM;
      end
      rcvg_pkg::P_NORM: begin
        priority if (c_zero)      state_next = rcvg_pkg::P_OUT;
        else if (!c_hi && c_mid)  state_next = rcvg_pkg::P_SQ;
        else                      state_next = rcvg_pkg::P_NORM;
      end
      rcvg_pkg::P_SQ: begin
        if (stp < 3'd3) begin
          ma = $signed({3'b000, cm[stp[1:0]][29:0]});
          mb = $signed({3'b000, cm[stp[1:0]][29:0]});
        end
        if (stp == 3'd3) state_next = rcvg_pkg::P_ROOT;
      end
      rcvg_pkg::P_ROOT: begin
        rd_req     = '{start: 1'b1, mode: rcvg_pkg::RD_SQRT};
        state_next = rcvg_pkg::P_RWAIT;
      end
      rcvg_pkg::P_RWAIT: begin
        if (rd_done) state_next = rcvg_pkg::P_DMUL;
      end
      rcvg_pkg::P_DMUL: begin
        ma         = $signed({3'b000, cm[stp[1:0]][29:0]});
        mb         = $signed({1'b0, hw});
        state_next = rcvg_pkg::P_DSTART;
      end
      rcvg_pkg::P_DSTART: begin
        rd_req     = '{start: 1'b1, mode: rcvg_pkg::RD_DIV};
        state_next = rcvg_pkg::P_DWAIT;
      end
      rcvg_pkg::P_DWAIT: begin
        if (rd_done) state_next = (stp == 3'd2) ? rcvg_pkg::P_OUT : rcvg_pkg::P_DMUL;
      end
      rcvg_pkg::P_OUT: begin
        state_next = rcvg_pkg::P_IDLE;
      end
      default: begin
        state_next = rcvg_pkg::P_IDLE;
      end
    endcase
  end

  // Done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == rcvg_pkg::P_OUT);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      rcvg_pkg::P_IDLE: begin
        stp <= '0;
        if (start) begin
          hw <= hw_in;
          for (int k = 0; k < 3; k++) begin
            p[k] <= p_in[k];
            t[k] <= tan_in[k];
            e[k] <= 33'(eye_in[k]) - 33'(p_in[k]);
          end
        end
      end
      rcvg_pkg::P_FIT: begin
        for (int k = 0; k < 3; k++) begin
          tf[k] <= fit_one(t[k], ts);
          ef[k] <= fit_one(e[k], es);
        end
      end
      rcvg_pkg::P_CROSS: begin
        // Pair up products: even one held, odd one subtracted
        if (stp != 3'd0) begin
          if (!j[0]) begin
            cacc <= prod62;
          end else begin
            cm[j[2:1]] <= cdiff[61] ? 61'(-cdiff) : cdiff[60:0];
            cs[j[2:1]] <= cdiff[61];
          end
        end
        stp <= (stp == 3'd6) ? 3'd0 : stp + 3'd1;
      end
      rcvg_pkg::P_NORM: begin
        // Walk the magnitude into [2^29, 2^30) one bit a cycle
        priority if (c_zero) begin
          for (int k = 0; k < 3; k++) q[k] <= '0;
        end else if (c_hi) begin
          for (int k = 0; k < 3; k++) cm[k] <= cm[k] >> 1;
        end else if (!c_mid) begin
          for (int k = 0; k < 3; k++) cm[k] <= cm[k] << 1;
        end else begin
          stp <= '0;
        end
      end
      rcvg_pkg::P_SQ: begin
        if (stp == 3'd1) sum <= prod62[61:0];
        else if (stp != 3'd0) sum <= sum + prod62[61:0];
        stp <= (stp == 3'd3) ? 3'd0 : stp + 3'd1;
      end
      rcvg_pkg::P_RWAIT: begin
        if (rd_done) begin
          len <= rd_root;
          stp <= '0;
        end
      end
      rcvg_pkg::P_DWAIT: begin
        if (rd_done) begin
          q[stp[1:0]] <= rd_quo;
          stp         <= stp + 3'd1;
        end
      end
      rcvg_pkg::P_OUT: begin
        for (int k = 0; k < 3; k++) begin
          lft[k] <= sat36(lsum[k]);
          rgt[k] <= sat36(rsum[k]);
        end
      end
      default: begin
        stp <= stp;
      end
    endcase
  end

endmodule

### design/ribbon_chain_vertex_generator_unit.sv
// Ribbon chain vertex generator top level: chain tracking, registers, output beat.
//
//  channel | direction | handshake          | payload
//  in      | sink      | in_valid/in_stall  | pos_x/y/z, half_width, tex_u, packed_colour, is_last
//  out     | source    | out_valid/out_stall| left_x/y/z, right_x/y/z, out_tex_u, out_colour,
//          |           |                    | element_index, final_pair
//  cfg     | APB slave | psel/penable       | eye_x, eye_y, eye_z at 0x0, 0x4, 0x8
//
// A vertex pair's time from its start until its beat is taken with no stall is set by 32 root
// steps, three 34-step divides and up to 31 normalize shifts; when the cross product is zero
// the root and divides are skipped. A last element adds a second pair, and the first element
// of a chain is stored without starting a pair. out_stall holds the beat.
// in_stall is high from an accepted element that starts a pair until its last beat leaves.
// Reset (rst, synchronous) clears the eye registers and the chain state.
module ribbon_chain_vertex_generator_unit #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [31:0]        half_width,
  input  logic signed [31:0] tex_u,
  input  logic [31:0]        packed_colour,
  input  logic               is_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] left_x,
  output logic signed [31:0] left_y,
  output logic signed [31:0] left_z,
  output logic signed [31:0] right_x,
  output logic signed [31:0] right_y,
  output logic signed [31:0] right_z,
  output logic signed [31:0] out_tex_u,
  output logic [31:0]        out_colour,
  output logic [9:0]         element_index,
  output logic               final_pair,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CW = $clog2(MAX_ELEMENTS);
  localparam logic [CW-1:0] LAST_IDX = CW'(MAX_ELEMENTS - 1);

  rcvg_pkg::top_state_t state, state_next;

  logic signed [31:0] eye   [3];
  logic signed [31:0] older [3];
  logic signed [31:0] pend  [3];
  logic signed [31:0] cur   [3];
  logic [31:0]        pend_hw, pend_tex, pend_col;
  logic [31:0]        cur_hw, cur_tex, cur_col;
  logic               cur_last;
  logic [CW-1:0]      cnt;

  logic               in_acc, out_acc, cfg_wr;
  logic               last_eff;
  logic               pair_start, pair_done;
  logic signed [31:0] pair_p   [3];
  logic signed [32:0] pair_tan [3];
  logic [31:0]        pair_hw;
  logic signed [31:0] pair_l   [3];
  logic signed [31:0] pair_r   [3];
  logic [CW+9:0]      idx_first, idx_second;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign in_stall = (state != rcvg_pkg::T_IDLE);
  assign last_eff = is_last || (cnt >= LAST_IDX);

  assign idx_first  = {10'd0, cnt - CW'(1)};
  assign idx_second = {10'd0, cnt};

  // Configuration writes and reads
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) eye[k] <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        rcvg_pkg::REG_EYE_X: eye[0] <= pwdata;
        rcvg_pkg::REG_EYE_Y: eye[1] <= pwdata;
        rcvg_pkg::REG_EYE_Z: eye[2] <= pwdata;
        default:             eye[0] <= eye[0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      rcvg_pkg::REG_EYE_X: prdata = eye[0];
      rcvg_pkg::REG_EYE_Y: prdata = eye[1];
      rcvg_pkg::REG_EYE_Z: prdata = eye[2];
      default:             prdata = '0;
    endcase
  end

  // Pick the element and tangent for the pair engine
  always_comb begin
    pair_start = (state == rcvg_pkg::T_GO1) || (state == rcvg_pkg::T_GO2);
    for (int k = 0; k < 3; k++) begin
      if (state == rcvg_pkg::T_GO2) begin
        pair_p[k]   = cur[k];
        pair_tan[k] = 33'(cur[k]) - 33'(pend[k]);
      end else begin
        pair_p[k]   = pend[k];
        pair_tan[k] = (cnt == CW'(1)) ? 33'(cur[k]) - 33'(pend[k])
                                      : 33'(cur[k]) - 33'(older[k]);
      end
    end
    pair_hw = (state == rcvg_pkg::T_GO2) ? cur_hw : pend_hw;
  end

  rcvg_pair u_pair (
    .clk    (clk),
    .rst    (rst),
    .start  (pair_start),
    .p_in   (pair_p),
    .tan_in (pair_tan),
    .eye_in (eye),
    .hw_in  (pair_hw),
    .done   (pair_done),
    .lft    (pair_l),
    .rgt    (pair_r)
  );

  // Hold the chain state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcvg_pkg::T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rcvg_pkg::T_IDLE: begin
        if (in_acc && (cnt != '0)) state_next = rcvg_pkg::T_GO1;
      end
      rcvg_pkg::T_GO1:  state_next = rcvg_pkg::T_RUN1;
      rcvg_pkg::T_RUN1: if (pair_done) state_next = rcvg_pkg::T_OUT1;
      rcvg_pkg::T_OUT1: begin
        if (out_acc) state_next = cur_last ? rcvg_pkg::T_GO2 : rcvg_pkg::T_IDLE;
      end
      rcvg_pkg::T_GO2:  state_next = rcvg_pkg::T_RUN2;
      rcvg_pkg::T_RUN2: if (pair_done) state_next = rcvg_pkg::T_OUT2;
      rcvg_pkg::T_OUT2: if (out_acc) state_next = rcvg_pkg::T_IDLE;
      default:          state_next = rcvg_pkg::T_IDLE;
    endcase
  end

  // Element count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == rcvg_pkg::T_IDLE && in_acc && cnt == '0 && !last_eff) cnt <= CW'(1);
      if (state == rcvg_pkg::T_OUT1 && out_acc && !cur_last) cnt <= cnt + CW'(1);
      if (state == rcvg_pkg::T_OUT2 && out_acc) cnt <= '0;
      if ((state == rcvg_pkg::T_RUN1 || state == rcvg_pkg::T_RUN2) && pair_done) begin
        out_valid <= 1'b1;
      end else if (out_acc) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Element registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        older[k] <= '0;
        pend[k]  <= '0;
      end
      pend_hw  <= '0;
      pend_tex <= '0;
      pend_col <= '0;
    end else begin
      if (state == rcvg_pkg::T_IDLE && in_acc) begin
        if (cnt == '0) begin
          if (!last_eff) begin
            pend[0]  <= pos_x;
            pend[1]  <= pos_y;
            pend[2]  <= pos_z;
            pend_hw  <= half_width;
            pend_tex <= tex_u;
            pend_col <= packed_colour;
          end
        end else begin
          cur[0]   <= pos_x;
          cur[1]   <= pos_y;
          cur[2]   <= pos_z;
          cur_hw   <= half_width;
          cur_tex  <= tex_u;
          cur_col  <= packed_colour;
          cur_last <= last_eff;
        end
      end
      // Advance the chain once the pending element has left
      if (state == rcvg_pkg::T_OUT1 && out_acc && !cur_last) begin
        for (int k = 0; k < 3; k++) begin
          older[k] <= pend[k];
          pend[k]  <= cur[k];
        end
        pend_hw  <= cur_hw;
        pend_tex <= cur_tex;
        pend_col <= cur_col;
      end
    end
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (pair_done) begin
      left_x  <= pair_l[0];
      left_y  <= pair_l[1];
      left_z  <= pair_l[2];
      right_x <= pair_r[0];
      right_y <= pair_r[1];
      right_z <= pair_r[2];
      if (state == rcvg_pkg::T_RUN2) begin
        out_tex_u     <= cur_tex;
        out_colour    <= cur_col;
        element_index <= idx_second[9:0];
        final_pair    <= 1'b1;
      end else begin
        out_tex_u     <= pend_tex;
        out_colour    <= pend_col;
        element_index <= idx_first[9:0];
        final_pair    <= 1'b0;
      end
    end
  end

endmodule

### design/rcvg_checker.sv
// Port-level checks for the ribbon chain vertex generator, bound to the top level.
module rcvg_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] left_x,
  input logic               final_pair
);

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(left_x) && $stable(final_pair))
    else $error("stalled output beat changed");

  // No input is taken while a beat waits
  a_busy_out: assert property (@(posedge clk) out_valid |-> in_stall)
    else $error("input ready while output beat pending");

  // Reset drops the output beat
  a_rst_clr: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Single output register: a taken beat leaves a gap
  a_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid)
    else $error("output beat repeated without gap");

endmodule

bind ribbon_chain_vertex_generator_unit rcvg_checker u_rcvg_checker (.*);

### dv/ribbon_chain_vertex_generator_unit_tb.sv
// Testbench for the ribbon chain vertex generator: directed table, random chains, scoreboard.
`timescale 1ns / 100ps

module ribbon_chain_vertex_generator_unit_tb;

  localparam int MAX_ELEMENTS = 1024;
  localparam longint LIMIT_CYCLES = 64'd4000000;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [31:0]        hw;
    logic signed [31:0] tex;
    logic [31:0]        col;
    logic               last;
  } element_t;

  typedef struct packed {
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    logic signed [31:0] lz;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] tex;
    logic [31:0]        col;
    logic [9:0]         idx;
    logic               fin;
  } vertex_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [31:0] half_width = '0;
  logic signed [31:0] tex_u = '0;
  logic [31:0] packed_colour = '0;
  logic is_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] left_x, left_y, left_z, right_x, right_y, right_z, out_tex_u;
  logic [31:0] out_colour;
  logic [9:0] element_index;
  logic final_pair;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ribbon_chain_vertex_generator_unit #(.MAX_ELEMENTS(MAX_ELEMENTS)) i_dut (.*);

  // Predictor state
  longint eye_v[3];
  longint older_pos[3];
  longint pend_pos[3];
  logic [31:0] pend_hw, pend_tex, pend_col;
  int unsigned chain_len;

  vertex_pair_t pair_queue[$];
  int errors = 0;
  longint cycles = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;
  int rx_wait = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("ribbon_chain_vertex_generator_unit verification failed");
      $finish;
    end
  end

  function automatic longint magn(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Shift toward zero until every magnitude sits below 2^30
  function automatic void fit_below30(ref longint v[3]);
    longint m;
    int s;
    m = magn(v[0]);
    if (magn(v[1]) > m) m = magn(v[1]);
    if (magn(v[2]) > m) m = magn(v[2]);
    s = 0;
    while ((m >>> s) >= (64'sd1 <<< 30)) s++;
    for (int k = 0; k < 3; k++)
      v[k] = v[k] < 0 ? -(magn(v[k]) >>> s) : (v[k] >>> s);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Build one vertex pair from a position, tangent and eye vector
  function automatic vertex_pair_t ribbon_pair(longint p[3], longint tg[3], logic [31:0] hw,
                                               logic [31:0] tex, logic [31:0] col,
                                               int unsigned idx, bit fin);
    vertex_pair_t vp;
    longint e[3], c[3], off[3];
    longint m;
    logic [63:0] sum, len, q;
    int s;
    for (int k = 0; k < 3; k++) begin
      e[k] = eye_v[k] - p[k];
      off[k] = 0;
    end
    fit_below30(tg);
    fit_below30(e);
    c[0] = tg[1] * e[2] - tg[2] * e[1];
    c[1] = tg[2] * e[0] - tg[0] * e[2];
    c[2] = tg[0] * e[1] - tg[1] * e[0];
    m = magn(c[0]);
    if (magn(c[1]) > m) m = magn(c[1]);
    if (magn(c[2]) > m) m = magn(c[2]);
    if (m != 0) begin
      if (m >= (64'sd1 <<< 30)) begin
        fit_below30(c);
      end else begin
        s = 0;
        while ((m <<< s) < (64'sd1 <<< 29)) s++;
        for (int k = 0; k < 3; k++) c[k] = c[k] <<< s;
      end
      sum = 0;
      for (int k = 0; k < 3; k++) sum += magn(c[k]) * magn(c[k]);
      len = root64(sum);
      for (int k = 0; k < 3; k++) begin
        q = (magn(c[k]) * {32'd0, hw} + (len >> 1)) / len;
        off[k] = c[k] < 0 ? -longint'(q) : longint'(q);
      end
    end
    vp.lx = sat32(p[0] - off[0]);
    vp.ly = sat32(p[1] - off[1]);
    vp.lz = sat32(p[2] - off[2]);
    vp.rx = sat32(p[0] + off[0]);
    vp.ry = sat32(p[1] + off[1]);
    vp.rz = sat32(p[2] + off[2]);
    vp.tex = tex;
    vp.col = col;
    vp.idx = idx[9:0];
    vp.fin = fin;
    return vp;
  endfunction

  // Advance the chain model by one element and queue the pairs it releases
  function automatic void predict_element(element_t el);
    longint p[3], tg[3];
    bit last;
    p[0] = el.px;
    p[1] = el.py;
    p[2] = el.pz;
    last = el.last || (chain_len >= MAX_ELEMENTS - 1);
    if (chain_len == 0) begin
      if (!last) begin
        pend_pos = p;
        pend_hw = el.hw;
        pend_tex = el.tex;
        pend_col = el.col;
        chain_len = 1;
      end
      return;
    end
    for (int k = 0; k < 3; k++)
      tg[k] = p[k] - (chain_len == 1 ? pend_pos[k] : older_pos[k]);
    pair_queue.push_back(ribbon_pair(pend_pos, tg, pend_hw, pend_tex, pend_col,
                                     chain_len - 1, 1'b0));
    if (last) begin
      for (int k = 0; k < 3; k++) tg[k] = p[k] - pend_pos[k];
      pair_queue.push_back(ribbon_pair(p, tg, el.hw, el.tex, el.col, chain_len, 1'b1));
      chain_len = 0;
    end else begin
      older_pos = pend_pos;
      pend_pos = p;
      pend_hw = el.hw;
      pend_tex = el.tex;
      pend_col = el.col;
      chain_len++;
    end
  endfunction

  task automatic write_eye(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    eye_v[idx] = longint'(signed'(val));
    @(posedge clk);
  endtask

  task automatic set_eye(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    write_eye(rcvg_pkg::REG_EYE_X, x);
    write_eye(rcvg_pkg::REG_EYE_Y, y);
    write_eye(rcvg_pkg::REG_EYE_Z, z);
  endtask

  // Offer one beat, wait for acceptance, then, if gaps is set, idle a random gap
  task automatic send_element(element_t el, bit gaps);
    int gap;
    pos_x <= el.px;
    pos_y <= el.py;
    pos_z <= el.pz;
    half_width <= el.hw;
    tex_u <= el.tex;
    packed_colour <= el.col;
    is_last <= el.last;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_element(el);
    gap = gaps ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pair_queue.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h0003ffff);
      3: return -$urandom_range(0, 32'h0003ffff);
      default: return $urandom;
    endcase
  endfunction

  function automatic element_t rand_element(bit last);
    element_t el;
    el.px = rand_word();
    el.py = rand_word();
    el.pz = rand_word();
    el.hw = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h000fffff);
    el.tex = $urandom;
    el.col = $urandom;
    el.last = last;
    return el;
  endfunction

  // Receiver: draw a wait per beat, one long hold-off, compare each beat
  always @(posedge clk) begin
    vertex_pair_t got, want;
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{left_x, left_y, left_z, right_x, right_y, right_z, out_tex_u, out_colour,
                element_index, final_pair};
        if (pair_queue.size() == 0) begin
          $error("unexpected beat, element_index %0d", element_index);
          errors++;
        end else begin
          want = pair_queue.pop_front();
          if (got.lx !== want.lx) begin $error("left_x exp %0d got %0d", want.lx, got.lx); errors++; end
          if (got.ly !== want.ly) begin $error("left_y exp %0d got %0d", want.ly, got.ly); errors++; end
          if (got.lz !== want.lz) begin $error("left_z exp %0d got %0d", want.lz, got.lz); errors++; end
          if (got.rx !== want.rx) begin $error("right_x exp %0d got %0d", want.rx, got.rx); errors++; end
          if (got.ry !== want.ry) begin $error("right_y exp %0d got %0d", want.ry, got.ry); errors++; end
          if (got.rz !== want.rz) begin $error("right_z exp %0d got %0d", want.rz, got.rz); errors++; end
          if (got.tex !== want.tex) begin
            $error("out_tex_u exp %h got %h", want.tex, got.tex); errors++;
          end
          if (got.col !== want.col) begin
            $error("out_colour exp %h got %h", want.col, got.col); errors++;
          end
          if (got.idx !== want.idx) begin
            $error("element_index exp %0d got %0d", want.idx, got.idx); errors++;
          end
          if (got.fin !== want.fin) begin
            $error("final_pair exp %0d got %0d", want.fin, got.fin); errors++;
          end
        end
        rx_wait = $urandom_range(0, 14);
      end else if (out_valid && out_stall && rx_wait != 0) begin
        rx_wait--;
      end
      out_stall <= hold_off || (rx_wait != 0);
    end
  end

  // Directed rows: position, half width, tex, colour, last
  element_t directed[$];

  initial begin
    element_t el;
    int n, sent;
    for (int k = 0; k < 3; k++) begin
      eye_v[k] = 0;
      older_pos[k] = 0;
      pend_pos[k] = 0;
    end
    chain_len = 0;
    pend_hw = 0;
    pend_tex = 0;
    pend_col = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single-element chain: no beat
    directed.push_back('{32'sh10000, 32'sh0, 32'sh0, 32'h10000, 32'sh0, 32'h0, 1'b1});
    // Straight chain along x, eye at origin
    directed.push_back('{32'sh0, 32'sh10000, 32'sh0, 32'h10000, 32'sh1, 32'hffffffff, 1'b0});
    directed.push_back('{32'sh10000, 32'sh10000, 32'sh0, 32'h20000, 32'sh2, 32'h0, 1'b0});
    directed.push_back('{32'sh20000, 32'sh10000, 32'sh0, 32'hffffffff, -32'sh1, 32'h1, 1'b1});
    // Zero perpendicular: repeated positions
    directed.push_back('{32'sh50000, 32'sh50000, 32'sh50000, 32'h10000, 32'sh0, 32'h0, 1'b0});
    directed.push_back('{32'sh50000, 32'sh50000, 32'sh50000, 32'h10000, 32'sh0, 32'h0, 1'b1});
    // Field extremes, saturation
    directed.push_back('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'hffffffff,
                         32'sh7fffffff, 32'h0, 1'b0});
    directed.push_back('{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'hffffffff,
                         32'sh80000000, 32'hffffffff, 1'b0});
    directed.push_back('{32'sh0, 32'sh0, 32'sh7fffffff, 32'h0, 32'sh0, 32'h0, 1'b1});
    foreach (directed[i]) send_element(directed[i], 1'b0);
    drain();

    // Over-long chain at the most distant eye, starting a new chain after it
    set_eye(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    for (int i = 0; i < MAX_ELEMENTS + 3; i++) begin
      el = rand_element(1'b0);
      send_element(el, 1'b0);
    end
    send_element(rand_element(1'b1), 1'b0);
    drain();

    // Long receiver hold-off while the sender keeps offering
    set_eye(32'h80000000, 32'h7fffffff, 32'h0);
    hold_off = 1'b1;
    fork
      begin
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_element(rand_element(i == 7), 1'b0);
    join
    drain();

    // Random chains under several eye settings
    sent = 0;
    while (sent < 950) begin
      if ($urandom_range(0, 7) == 0) begin
        drain();
        set_eye(rand_word(), rand_word(), rand_word());
      end
      n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
      for (int i = 0; i < n; i++) begin
        el = rand_element(i == n - 1);
        if ($urandom_range(0, 40) == 0) el.last = ~el.last;
        send_element(el, $urandom_range(0, 3) != 0);
      end
      sent += n;
    end
    send_element(rand_element(1'b1), 1'b1);
    drain();

    if (errors == 0 && pair_queue.size() == 0) begin
      $display("ribbon_chain_vertex_generator_unit verification clean");
    end else begin
      $display("ribbon_chain_vertex_generator_unit verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/rcvg_pkg.sv
design/rcvg_mul.sv
design/rcvg_rootdiv.sv
design/rcvg_pair.sv
design/ribbon_chain_vertex_generator_unit.sv
design/rcvg_checker.sv
dv/ribbon_chain_vertex_generator_unit_tb.sv
